@@ rtl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the top-k boundary picker
// Holds the payload structs, the fixed field widths, the row command codes
// and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // Fixed field widths.
  localparam int VALUE_WIDTH   = 16;
  localparam int SEP_WIDTH     = 12;
  localparam int OUT_POS_WIDTH = 13;

  // Reset value of the minimum separation register.
  localparam logic [SEP_WIDTH-1:0] SEP_RESET = 12'd5;

  // Position code for an empty result slot (minus one).
  localparam logic [OUT_POS_WIDTH-1:0] PAD_POSITION = '1;

  // Operations on the row of kept entries.
  localparam logic [2:0] ROW_HOLD      = 3'd0;
  localparam logic [2:0] ROW_INSERT    = 3'd1;
  localparam logic [2:0] ROW_SORT_EVEN = 3'd2;
  localparam logic [2:0] ROW_SORT_ODD  = 3'd3;
  localparam logic [2:0] ROW_SHIFT     = 3'd4;
  localparam logic [2:0] ROW_CLEAR     = 3'd5;

  // One input item.
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] difference_value;
    logic                          last_item;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic signed [OUT_POS_WIDTH-1:0] boundary_position;
    logic                            last_result;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic [2:0] row_op;
    logic       out_load;
    logic       out_pad;
    logic       out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_valid;
    logic head_keep;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/tbp_datapath.sv @@
// ----------------------------------------------------------------------------
// tbp_datapath: row of kept entries, separation filter and result register
// The row inserts one magnitude per ROW_INSERT cycle in descending order, sorts itself
// by position with odd-even transposition and shifts entries out at its head.
// ----------------------------------------------------------------------------
module tbp_datapath #(
  parameter int TOP_COUNT  = 12,
  parameter int MAX_LENGTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tbp_pkg::dp_cmd_t                    cmd,
  output tbp_pkg::dp_status_t                 status,
  input  logic signed [tbp_pkg::VALUE_WIDTH-1:0] difference_value,
  input  logic                                cfg_we,
  input  logic [tbp_pkg::SEP_WIDTH-1:0]       cfg_wdata,
  output logic                                result_valid,
  input  logic                                result_ready,
  output tbp_pkg::result_t                    result
);

  localparam int VW    = tbp_pkg::VALUE_WIDTH;
  localparam int SW    = tbp_pkg::SEP_WIDTH;
  localparam int OW    = tbp_pkg::OUT_POS_WIDTH;
  localparam int POS_W = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int CMP_W = (POS_W > SW) ? POS_W : SW;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH - 1);

  // Row of entries.
  logic [VW-1:0]    mag      [TOP_COUNT];
  logic [POS_W-1:0] pos      [TOP_COUNT];
  logic             vld      [TOP_COUNT];
  logic [VW-1:0]    mag_next [TOP_COUNT];
  logic [POS_W-1:0] pos_next [TOP_COUNT];
  logic             vld_next [TOP_COUNT];

  logic [POS_W-1:0] pos_cnt;
  logic [SW-1:0]    min_sep;
  logic [POS_W-1:0] last_pos;
  logic             have_last;
  logic             out_valid;
  tbp_pkg::result_t out_reg;

  logic [VW-1:0]    raw;
  logic [VW-1:0]    in_mag;
  logic             take [TOP_COUNT];
  logic             swap [TOP_COUNT];
  logic [POS_W-1:0] gap;
  logic [POS_W+OW-1:0] pos_wide;

  // Magnitude of the incoming value; the most negative value maps to 2^(VW-1).
  assign raw    = difference_value;
  assign in_mag = raw[VW-1] ? ((~raw) + VW'(1)) : raw;

  // Insert and compare-exchange decisions, one per cell.
  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      take[i] = !vld[i] || (in_mag > mag[i]);
      swap[i] = 1'b0;
      if (i + 1 < TOP_COUNT) begin
        swap[i] = {!vld[i], pos[i]} > {!vld[(i + 1) % TOP_COUNT], pos[(i + 1) % TOP_COUNT]};
      end
    end
  end

  // Next state of the row.
  always_comb begin
    mag_next = mag;
    pos_next = pos;
    vld_next = vld;
    unique case (cmd.row_op) inside
      tbp_pkg::ROW_INSERT: begin
        if (take[0]) begin
          mag_next[0] = in_mag;
          pos_next[0] = pos_cnt;
          vld_next[0] = 1'b1;
        end
        for (int i = 1; i < TOP_COUNT; i++) begin
          if (take[i-1]) begin
            mag_next[i] = mag[i-1];
            pos_next[i] = pos[i-1];
            vld_next[i] = vld[i-1];
          end else if (take[i]) begin
            mag_next[i] = in_mag;
            pos_next[i] = pos_cnt;
            vld_next[i] = 1'b1;
          end
        end
      end
      tbp_pkg::ROW_SORT_EVEN, tbp_pkg::ROW_SORT_ODD: begin
        for (int i = 0; i + 1 < TOP_COUNT; i++) begin
          if ((((i % 2) == 1) == (cmd.row_op == tbp_pkg::ROW_SORT_ODD)) && swap[i]) begin
            mag_next[i]     = mag[i+1];
            pos_next[i]     = pos[i+1];
            vld_next[i]     = vld[i+1];
            mag_next[i+1]   = mag[i];
            pos_next[i+1]   = pos[i];
            vld_next[i+1]   = vld[i];
          end
        end
      end
      tbp_pkg::ROW_SHIFT: begin
        for (int i = 0; i + 1 < TOP_COUNT; i++) begin
          mag_next[i] = mag[i+1];
          pos_next[i] = pos[i+1];
          vld_next[i] = vld[i+1];
        end
        vld_next[TOP_COUNT-1] = 1'b0;
      end
      tbp_pkg::ROW_CLEAR: begin
        for (int i = 0; i < TOP_COUNT; i++) begin
          vld_next[i] = 1'b0;
        end
      end
      tbp_pkg::ROW_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  // Row registers; payload needs no reset.
  always_ff @(posedge clk) begin
    mag <= mag_next;
    pos <= pos_next;
    if (rst) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld <= vld_next;
    end
  end

  // Position counter saturates at the last position.
  always_ff @(posedge clk) begin
    if (rst || cmd.row_op == tbp_pkg::ROW_CLEAR) begin
      pos_cnt <= '0;
    end else if (cmd.row_op == tbp_pkg::ROW_INSERT && pos_cnt != POS_MAX) begin
      pos_cnt <= pos_cnt + POS_W'(1);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_sep <= tbp_pkg::SEP_RESET;
    end else if (cfg_we) begin
      min_sep <= cfg_wdata;
    end
  end

  // Separation filter against the last kept position.
  assign gap = pos[0] - last_pos;

  always_ff @(posedge clk) begin
    if (rst || cmd.row_op == tbp_pkg::ROW_CLEAR) begin
      have_last <= 1'b0;
    end else if (cmd.out_load && !cmd.out_pad) begin
      have_last <= 1'b1;
    end
    if (cmd.out_load && !cmd.out_pad) begin
      last_pos <= pos[0];
    end
  end

  // Result register.
  assign pos_wide = {{OW{1'b0}}, pos[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_reg.boundary_position <= cmd.out_pad ? tbp_pkg::PAD_POSITION : pos_wide[OW-1:0];
      out_reg.last_result       <= cmd.out_last;
    end
  end

  assign result_valid      = out_valid;
  assign result            = out_reg;
  assign status.head_valid = vld[0];
  assign status.head_keep  = !have_last || (CMP_W'(gap) >= CMP_W'(min_sep));
  assign status.out_free   = !out_valid || result_ready;

endmodule

@@ rtl/tbp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbp_ctrl: sequencer of the top-k boundary picker
// Takes items while idle, runs the position sort rounds after the last item
// and then drives the result scan and the final clear.
// ----------------------------------------------------------------------------
module tbp_ctrl #(
  parameter int TOP_COUNT = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  input  logic                last_item,
  output logic                sample_ready,
  input  tbp_pkg::dp_status_t status,
  output tbp_pkg::dp_cmd_t    cmd
);

  localparam int STEP_W = $clog2(TOP_COUNT + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOP_COUNT - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  // Next state and commands.
  always_comb begin
    state_next   = state;
    step_next    = step;
    sample_ready = 1'b0;
    cmd          = '0;
    cmd.row_op   = tbp_pkg::ROW_HOLD;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.row_op = tbp_pkg::ROW_INSERT;
          if (last_item) begin
            state_next = ST_SORT;
            step_next  = '0;
          end
        end
      end
      ST_SORT: begin
        cmd.row_op = step[0] ? tbp_pkg::ROW_SORT_ODD : tbp_pkg::ROW_SORT_EVEN;
        if (step == LAST_STEP) begin
          state_next = ST_SCAN;
          step_next  = '0;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_SCAN: begin
        if (status.out_free) begin
          if (status.head_valid && !status.head_keep) begin
            // Too close to the previous kept boundary: drop it.
            cmd.row_op = tbp_pkg::ROW_SHIFT;
          end else begin
            cmd.out_load = 1'b1;
            cmd.out_pad  = !status.head_valid;
            cmd.out_last = (step == LAST_STEP);
            if (step == LAST_STEP) begin
              cmd.row_op = tbp_pkg::ROW_CLEAR;
              state_next = ST_IDLE;
              step_next  = '0;
            end else begin
              cmd.row_op = tbp_pkg::ROW_SHIFT;
              step_next  = step + STEP_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ rtl/top_k_boundary_picker.sv @@
// ----------------------------------------------------------------------------
// top_k_boundary_picker: keeps the profile differences of largest magnitude and emits
// their positions in ascending order, thinned by a minimum separation.
//
//   Channel   Direction  Handshake                  Payload
//   sample    in         sample_valid/sample_ready  tbp_pkg::sample_t
//   result    out        result_valid/result_ready  tbp_pkg::result_t
//   cfg       in         cfg_we (no wait)           min_separation
//
// An item not marked last is inserted in place by the cell row, and the block
// can take another item at once. An item marked last adds TOP_COUNT sort rounds
// in the cell row, then a result scan that emits TOP_COUNT results and drops
// each entry that breaks the separation rule (at most TOP_COUNT-1); the scan
// stalls while the result side holds the result register.
// Reset is synchronous: it empties the row, zeroes the position counter and
// sets min_separation to 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_boundary_picker #(
  parameter int TOP_COUNT  = 12,
  parameter int MAX_LENGTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  tbp_pkg::sample_t              sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output tbp_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [tbp_pkg::SEP_WIDTH-1:0] cfg_wdata
);

  tbp_pkg::dp_cmd_t    cmd;
  tbp_pkg::dp_status_t status;

  // Sequencer.
  tbp_ctrl #(
    .TOP_COUNT (TOP_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_item    (sample.last_item),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Entry row, filter and result register.
  tbp_datapath #(
    .TOP_COUNT  (TOP_COUNT),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .difference_value (sample.difference_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result           (result)
  );

`ifndef SYNTHESIS
  // After a last item the block stops taking items until its last result is loaded into the result register.
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && sample.last_item |=> !sample_ready)
    else $error("item taken right after a last item");

  // The result register is only loaded when it is free.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result register overwritten");

  // Items are only inserted while the input side is open.
  assert property (@(posedge clk) disable iff (rst)
    cmd.row_op == tbp_pkg::ROW_INSERT |-> sample_ready && sample_valid)
    else $error("insert without a transfer");
`endif

endmodule
